/* sv/fpe_pkg.sv */
// Package for the format print engine: constants, character codes and types.
// No dependencies; used by the interfaces and by format_print_engine_unit.
package fpe_pkg;

  // Field widths of the input and output words
  localparam int unsigned KindW = 2;
  localparam int unsigned CharW = 8;
  localparam int unsigned IntW  = 32;

  // Parameter defaults
  localparam int unsigned WidthLimitDef = 63;
  localparam int unsigned IntBitsDef    = 32;

  // Most decimal digits of a 32-bit magnitude
  localparam int unsigned MaxDigits = 10;
  localparam int unsigned DigIdxW   = $clog2(MaxDigits + 1);

  // Reciprocal of ten: q = (x * Recip10) >> Recip10Shift for any 32-bit x
  localparam logic [31:0] Recip10      = 32'hCCCC_CCCD;
  localparam int unsigned Recip10Shift = 35;

  // Character codes
  localparam logic [CharW-1:0] ChNul   = 8'h00;
  localparam logic [CharW-1:0] ChPct   = 8'h25;
  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChSpace = 8'h20;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChLowS  = 8'h73;
  localparam logic [CharW-1:0] ChLowD  = 8'h64;

  // Input word kinds
  typedef enum logic [KindW-1:0] {
    KIND_FMT     = 2'd0,
    KIND_INT     = 2'd1,
    KIND_STR_CHR = 2'd2,
    KIND_STR_END = 2'd3
  } kind_e;

endpackage

/* sv/fpe_in_if.sv */
// Input channel of the format print engine: valid/ready plus the input word.
// Depends on fpe_pkg for field widths.
interface fpe_in_if;
  logic                         valid;
  logic                         ready;
  logic [fpe_pkg::KindW-1:0]    item_kind;
  logic [fpe_pkg::CharW-1:0]    char_in;
  logic signed [fpe_pkg::IntW-1:0] int_value;

  modport source (output valid, item_kind, char_in, int_value, input ready);
  modport sink   (input valid, item_kind, char_in, int_value, output ready);
endinterface

/* sv/fpe_out_if.sv */
// Output channel of the format print engine: valid/ready plus one character word.
// Depends on fpe_pkg for field widths.
interface fpe_out_if;
  logic                      valid;
  logic                      ready;
  logic [fpe_pkg::CharW-1:0] out_char;
  logic                      last_of_run;

  modport source (output valid, out_char, last_of_run, input ready);
  modport sink   (input valid, out_char, last_of_run, output ready);
endinterface

/* sv/format_print_engine_unit.sv */
// Streaming printf-style formatter: plain text, %%, %s and %[0][width]d.
// Depends on fpe_pkg, fpe_in_if and fpe_out_if.
//
// A pass-through character is in the output register the cycle after acceptance.
// A %d argument with d digits spends a reciprocal multiply step and a remainder step per digit
// on the shared divider, then a step to size the padding, then loads 1 character per cycle
// while the sink takes words, N = max(width, d+sign) characters in all (width limit 63 by default).
// Input: next word once the sequencer is idle and the output slot is free; reset
// clears parse mode, flag, width, sequencer state and the output valid.
module format_print_engine_unit #(
  parameter int unsigned WIDTH_LIMIT = fpe_pkg::WidthLimitDef,
  parameter int unsigned INT_BITS    = fpe_pkg::IntBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fpe_in_if.sink     item_i,
  fpe_out_if.source  char_o
);

  localparam int unsigned NB   = (INT_BITS < 32) ? INT_BITS : 32;
  localparam int unsigned FwW  = $clog2(WIDTH_LIMIT + 1);
  localparam int unsigned DiW  = fpe_pkg::DigIdxW;
  localparam int unsigned CW   = fpe_pkg::CharW;

  typedef enum logic [2:0] {
    M_PLAIN, M_PCT, M_WIDTH, M_STR, M_INT
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_REM, S_PREP, S_SP, S_SIGN, S_ZERO, S_DIG
  } state_e;

  state_e            state_q, state_d;
  mode_e             mode_q, mode_d;
  logic              zp_q, zp_d;
  logic [FwW-1:0]    fw_q, fw_d;
  logic [NB-1:0]     mag_q, mag_d;
  logic [NB-1:0]     quo_q, quo_d;
  logic              neg_q, neg_d;
  logic [DiW-1:0]    len_q, len_d;
  logic [FwW-1:0]    pad_q, pad_d;
  logic              ov_q, ov_d;
  logic [CW-1:0]     oc_q, oc_d;
  logic              ol_q, ol_d;
  logic [3:0]        dig_q [fpe_pkg::MaxDigits];

  logic              can_load, in_fire;
  logic              emit_v, emit_l;
  logic [CW-1:0]     emit_c;
  logic [63:0]       prod;
  logic [NB-1:0]     rem_w;
  logic [3:0]        dig_w;
  logic              dig_we;
  logic [NB-1:0]     raw_w;
  logic [FwW+3:0]    wnext;
  logic [FwW:0]      used_w;
  logic [DiW-1:0]    rd_idx;
  logic              is_digit;

  assign can_load     = !ov_q || char_o.ready;
  assign item_i.ready = (state_q == S_IDLE) && can_load;
  assign in_fire      = item_i.valid && item_i.ready;

  assign char_o.valid       = ov_q;
  assign char_o.out_char    = oc_q;
  assign char_o.last_of_run = ol_q;

  // Shared divide-by-ten unit: reciprocal multiply, then remainder by shift-and-subtract
  assign prod  = 64'(mag_q) * 64'(fpe_pkg::Recip10);
  assign rem_w = mag_q - (quo_q << 3) - (quo_q << 1);
  assign dig_w = rem_w[3:0];

  assign raw_w    = item_i.int_value[NB-1:0];
  assign is_digit = (item_i.char_in >= fpe_pkg::ChZero) && (item_i.char_in <= fpe_pkg::ChNine);
  assign wnext    = ({4'b0, fw_q} * (FwW+4)'(10))
                  + (FwW+4)'(item_i.char_in - fpe_pkg::ChZero);
  assign used_w   = (FwW+1)'(len_q) + (FwW+1)'(neg_q);
  assign rd_idx   = len_q - DiW'(1);

  // Next-state logic of the sequencer and the parser
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    zp_d    = zp_q;
    fw_d    = fw_q;
    mag_d   = mag_q;
    quo_d   = quo_q;
    neg_d   = neg_q;
    len_d   = len_q;
    pad_d   = pad_q;
    emit_v  = 1'b0;
    emit_c  = item_i.char_in;
    emit_l  = 1'b1;
    dig_we  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (mode_q)
            M_PLAIN: begin
              if (item_i.item_kind == fpe_pkg::KIND_FMT) begin
                if (item_i.char_in == fpe_pkg::ChNul) begin
                  zp_d = 1'b0;
                  fw_d = '0;
                end else if (item_i.char_in == fpe_pkg::ChPct) begin
                  mode_d = M_PCT;
                end else begin
                  emit_v = 1'b1;
                end
              end
            end
            M_PCT, M_WIDTH: begin
              if (item_i.item_kind == fpe_pkg::KIND_FMT) begin
                if (item_i.char_in == fpe_pkg::ChNul) begin
                  mode_d = M_PLAIN;
                  zp_d   = 1'b0;
                  fw_d   = '0;
                end else if (mode_q == M_PCT && item_i.char_in == fpe_pkg::ChZero) begin
                  zp_d   = 1'b1;
                  mode_d = M_WIDTH;
                end else if (is_digit) begin
                  fw_d   = (wnext > (FwW+4)'(WIDTH_LIMIT)) ? FwW'(WIDTH_LIMIT)
                                                            : wnext[FwW-1:0];
                  mode_d = M_WIDTH;
                end else if (item_i.char_in == fpe_pkg::ChLowS) begin
                  mode_d = M_STR;
                end else if (item_i.char_in == fpe_pkg::ChLowD) begin
                  mode_d = M_INT;
                end else begin
                  // percent sign prints itself; unknown specifiers drop
                  emit_v = (item_i.char_in == fpe_pkg::ChPct);
                  mode_d = M_PLAIN;
                  zp_d   = 1'b0;
                  fw_d   = '0;
                end
              end
            end
            M_STR: begin
              if (item_i.item_kind == fpe_pkg::KIND_STR_END ||
                  (item_i.item_kind == fpe_pkg::KIND_STR_CHR &&
                   item_i.char_in == fpe_pkg::ChNul)) begin
                mode_d = M_PLAIN;
                zp_d   = 1'b0;
                fw_d   = '0;
              end else if (item_i.item_kind == fpe_pkg::KIND_STR_CHR) begin
                emit_v = 1'b1;
              end
            end
            M_INT: begin
              if (item_i.item_kind == fpe_pkg::KIND_INT) begin
                neg_d   = raw_w[NB-1];
                mag_d   = raw_w[NB-1] ? (NB'(0) - raw_w) : raw_w;
                len_d   = '0;
                state_d = S_DIV;
              end
            end
            default: begin
              mode_d = M_PLAIN;
              zp_d   = 1'b0;
              fw_d   = '0;
            end
          endcase
        end
      end
      S_DIV: begin
        quo_d   = NB'(prod >> fpe_pkg::Recip10Shift);
        state_d = S_REM;
      end
      S_REM: begin
        dig_we  = 1'b1;
        len_d   = len_q + DiW'(1);
        mag_d   = quo_q;
        state_d = (quo_q == '0) ? S_PREP : S_DIV;
      end
      S_PREP: begin
        pad_d = (FwW+1)'(fw_q) > used_w ? FwW'((FwW+1)'(fw_q) - used_w) : '0;
        if (!zp_q && pad_d != '0) begin
          state_d = S_SP;
        end else if (neg_q) begin
          state_d = S_SIGN;
        end else if (zp_q && pad_d != '0) begin
          state_d = S_ZERO;
        end else begin
          state_d = S_DIG;
        end
      end
      S_SP: begin
        emit_v = 1'b1;
        emit_c = fpe_pkg::ChSpace;
        emit_l = 1'b0;
        if (can_load) begin
          pad_d = pad_q - FwW'(1);
          if (pad_q == FwW'(1)) begin
            state_d = neg_q ? S_SIGN : S_DIG;
          end
        end
      end
      S_SIGN: begin
        emit_v = 1'b1;
        emit_c = fpe_pkg::ChMinus;
        emit_l = 1'b0;
        if (can_load) begin
          state_d = (zp_q && pad_q != '0) ? S_ZERO : S_DIG;
        end
      end
      S_ZERO: begin
        emit_v = 1'b1;
        emit_c = fpe_pkg::ChZero;
        emit_l = 1'b0;
        if (can_load) begin
          pad_d = pad_q - FwW'(1);
          if (pad_q == FwW'(1)) begin
            state_d = S_DIG;
          end
        end
      end
      S_DIG: begin
        emit_v = 1'b1;
        emit_c = fpe_pkg::ChZero + CW'(dig_q[rd_idx]);
        emit_l = (len_q == DiW'(1));
        if (can_load) begin
          len_d = len_q - DiW'(1);
          if (len_q == DiW'(1)) begin
            state_d = S_IDLE;
            mode_d  = M_PLAIN;
            zp_d    = 1'b0;
            fw_d    = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: load a word when the slot is free, drop valid when taken
  always_comb begin
    ov_d = ov_q;
    oc_d = oc_q;
    ol_d = ol_q;
    if (char_o.ready) begin
      ov_d = 1'b0;
    end
    if (emit_v && can_load) begin
      ov_d = 1'b1;
      oc_d = emit_c;
      ol_d = emit_l;
    end
  end

  // Hold state, parser registers and the output valid and last flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= M_PLAIN;
      zp_q    <= 1'b0;
      fw_q    <= '0;
      len_q   <= '0;
      pad_q   <= '0;
      neg_q   <= 1'b0;
      ov_q    <= 1'b0;
      ol_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      zp_q    <= zp_d;
      fw_q    <= fw_d;
      len_q   <= len_d;
      pad_q   <= pad_d;
      neg_q   <= neg_d;
      ov_q    <= ov_d;
      ol_q    <= ol_d;
    end
  end

  // Payload registers: magnitude, quotient, character and digit store
  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    quo_q <= quo_d;
    oc_q  <= oc_d;
    if (dig_we) begin
      dig_q[len_q] <= dig_w;
    end
  end

  // Digit count stays within the store
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= DiW'(fpe_pkg::MaxDigits))
    else $error("digit count overflow");

  // Field width never passes the limit
  a_fw_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fw_q <= FwW'(WIDTH_LIMIT))
    else $error("field width above limit");

  // A digit word carries a decimal character
  a_digit_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIG && can_load) |=> (oc_q >= fpe_pkg::ChZero && oc_q <= fpe_pkg::ChNine))
    else $error("digit word out of range");

  // The final digit closes the run and returns the parser to plain text
  a_last_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIG && can_load && len_q == DiW'(1)) |=>
      (ol_q && ov_q && state_q == S_IDLE && mode_q == M_PLAIN))
    else $error("conversion did not close");

  // Output word is never overwritten while it waits
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !char_o.ready) |=> ($stable(oc_q) && $stable(ol_q)))
    else $error("waiting word overwritten");

endmodule
